// File: hdl/mts_pkg.sv
package mts_pkg;

  localparam int unsigned VALUE_BITS = 30;
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef logic [VALUE_BITS-1:0]        value_t;
  typedef logic signed [VALUE_BITS:0]   word_t;   // stored entry, may be encoded (negative)
  typedef logic signed [VALUE_BITS+1:0] wide_t;

  typedef struct packed {
    logic   mode;
    value_t push_value;
  } req_t;

  typedef struct packed {
    value_t top_value;
    value_t min_value;
    logic   is_empty;
    logic   push_dropped;
  } rsp_t;

  // 2*v - m, only used when v < m so the result fits a word
  function automatic word_t enc_word(value_t v, value_t m);
    wide_t t;
    t = $signed({1'b0, v, 1'b0}) - $signed({2'b00, m});
    return t[VALUE_BITS:0];
  endfunction

  // previous minimum from an encoded top: 2*m - w
  function automatic value_t restore_min(word_t w, value_t m);
    wide_t t;
    t = $signed({1'b0, m, 1'b0}) - $signed({w[VALUE_BITS], w});
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic logic is_encoded(word_t w, value_t m);
    word_t mw;
    mw = {1'b0, m};
    return w < mw;
  endfunction

  // encoded entry stands for the current minimum itself
  function automatic value_t top_decode(word_t w, value_t m);
    return is_encoded(w, m) ? m : w[VALUE_BITS-1:0];
  endfunction

endpackage

// File: hdl/min_tracking_stack_core.sv
// channel | direction | handshake                | payload
// request | in        | in_valid_i / in_stall_o  | in_req_i  (mode, push_value)
// result  | out       | out_valid_o / out_stall_i | out_rsp_o (top, min, empty, dropped)
//
// Push, dropped push, pop on empty and pop of the last entry: answered from the idle state.
// Pop leaving entries: waits in the fill state for the RAM read of the new top.
// The top word is cached in a register; the RAM holds every entry.
// Reset clears count, minimum and handshake state; RAM contents need no clearing.
// A stalled result holds in the output register; a new request is taken in the
// same cycle the waiting result is taken.
module min_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mts_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mts_pkg::rsp_t out_rsp_o
);
  import mts_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FILL = 2'b10
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  value_t        min_q, min_d;
  word_t         top_q, top_d;
  logic          out_valid_q;
  rsp_t          out_q, out_d;
  logic          load_out;

  logic          accept, out_free, is_push, empty, full;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  word_t         wdata, rdata;
  logic [CW-1:0] rd_cnt;

  mts_ram #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = (in_req_i.mode == OP_PUSH);
  assign empty      = (count_q == '0);
  assign full       = (count_q == FULL_CNT);
  assign rd_cnt     = count_q - CW'(2);
  assign waddr      = count_q[AW-1:0];
  assign raddr      = rd_cnt[AW-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    min_d    = min_q;
    top_d    = top_q;
    load_out = 1'b0;
    out_d    = '0;
    we       = 1'b0;
    re       = 1'b0;
    wdata    = {1'b0, in_req_i.push_value};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_push) begin
            load_out = 1'b1;
            if (full) begin
              out_d.top_value    = top_decode(top_q, min_q);
              out_d.min_value    = min_q;
              out_d.push_dropped = 1'b1;
            end else begin
              we = 1'b1;
              if (empty || in_req_i.push_value >= min_q) begin
                wdata = {1'b0, in_req_i.push_value};
              end else begin
                wdata = enc_word(in_req_i.push_value, min_q);
              end
              if (empty || in_req_i.push_value < min_q) begin
                min_d = in_req_i.push_value;
              end
              top_d           = wdata;
              count_d         = count_q + CW'(1);
              out_d.top_value = in_req_i.push_value;
              out_d.min_value = min_d;
            end
          end else if (empty) begin
            load_out       = 1'b1;
            out_d.is_empty = 1'b1;
          end else begin
            if (is_encoded(top_q, min_q)) begin
              min_d = restore_min(top_q, min_q);
            end
            count_d = count_q - CW'(1);
            if (count_q == CW'(1)) begin
              load_out       = 1'b1;
              out_d.is_empty = 1'b1;
            end else begin
              re      = 1'b1;
              state_d = ST_FILL;
            end
          end
        end
      end
      ST_FILL: begin
        if (out_free) begin
          top_d           = rdata;
          load_out        = 1'b1;
          out_d.top_value = top_decode(rdata, min_q);
          out_d.min_value = min_q;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      min_q   <= min_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("stack count beyond depth");

  a_fill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> in_stall_o)
    else $error("request taken during top refill");

  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_push && count_q > CW'(1) |=> state_q == ST_FILL)
    else $error("pop leaving entries did not refill top");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_empty |-> out_q.top_value == '0 && out_q.min_value == '0)
    else $error("empty result carries nonzero values");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("result overwrote a waiting result");
`endif

endmodule

// File: hdl/mts_ram.sv
module mts_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [ADDR_W-1:0]  waddr_i,
  input  mts_pkg::word_t     wdata_i,
  input  logic               re_i,
  input  logic [ADDR_W-1:0]  raddr_i,
  output mts_pkg::word_t     rdata_o
);
  import mts_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/tb_min_tracking_stack_core.sv
module tb_min_tracking_stack_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int LIMIT = 300000;
  localparam int HOLD_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  min_tracking_stack_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // request source and result store
  req_t pending_reqs[$];
  rsp_t expected_stack_rsp[$];
  int   issued_reqs = 0;
  int   taken_reqs = 0;
  int   errors = 0;
  int   cycles = 0;
  bit   req_taken = 1'b0;

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_reqs = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  // shadow of the stack, updated on each accepted request
  word_t  stack_mem [DEPTH];
  int     depth_used = 0;
  value_t cur_min = '0;

  // generator side
  int     gen_count = 0;
  value_t last_push = '0;

  function automatic rsp_t stack_op(req_t r);
    rsp_t   rsp;
    longint v;
    longint m;
    longint w;
    rsp = '0;
    v = longint'(r.push_value);
    m = longint'(cur_min);
    if (r.mode == OP_PUSH) begin
      if (depth_used >= DEPTH) begin
        rsp.push_dropped = 1'b1;
      end else if (depth_used == 0) begin
        stack_mem[0] = word_t'(v);
        cur_min = r.push_value;
        depth_used = 1;
      end else begin
        if (v >= m) begin
          stack_mem[depth_used] = word_t'(v);
        end else begin
          // below the minimum: keep 2v - m so the old minimum can be recovered
          stack_mem[depth_used] = word_t'(2 * v - m);
          cur_min = r.push_value;
        end
        depth_used++;
      end
    end else if (depth_used != 0) begin
      w = longint'(stack_mem[depth_used-1]);
      if (w < m) cur_min = value_t'(2 * m - w);
      depth_used--;
    end
    if (depth_used != 0) begin
      w = longint'(stack_mem[depth_used-1]);
      m = longint'(cur_min);
      rsp.top_value = (w < m) ? cur_min : value_t'(w);
      rsp.min_value = cur_min;
    end else begin
      rsp.is_empty = 1'b1;
    end
    return rsp;
  endfunction

  // accept side of the request channel
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_stack_rsp.push_back(stack_op(in_req_i));
      taken_reqs++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // long receiver hold-off, counted here
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stack_rsp.size() == 0) begin
        $error("result with no request waiting: top %0d min %0d",
               out_rsp_o.top_value, out_rsp_o.min_value);
        errors++;
      end else begin
        want = expected_stack_rsp.pop_front();
        if (out_rsp_o.top_value !== want.top_value) begin
          $error("top_value: expected %0d, actual %0d", want.top_value, out_rsp_o.top_value);
          errors++;
        end
        if (out_rsp_o.min_value !== want.min_value) begin
          $error("min_value: expected %0d, actual %0d", want.min_value, out_rsp_o.min_value);
          errors++;
        end
        if (out_rsp_o.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, out_rsp_o.is_empty);
          errors++;
        end
        if (out_rsp_o.push_dropped !== want.push_dropped) begin
          $error("push_dropped: expected %0d, actual %0d",
                 want.push_dropped, out_rsp_o.push_dropped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("min_tracking_stack_core: mismatch");
      $finish;
    end
  end

  task automatic add_req(logic mode, value_t val);
    req_t r;
    r.mode = mode;
    r.push_value = val;
    pending_reqs.push_back(r);
    issued_reqs++;
    if (mode == OP_PUSH) begin
      last_push = val;
      if (gen_count < DEPTH) gen_count++;
    end else if (gen_count != 0) begin
      gen_count--;
    end
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return value_t'($urandom_range(0, 31));
      3: return last_push;
      4: return last_push >> $urandom_range(1, 4);
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic add_random(int n);
    int push_pct;
    for (int i = 0; i < n; i++) begin
      push_pct = (gen_count == 0) ? 75 : 55;
      if ($urandom_range(0, 99) < push_pct) add_req(OP_PUSH, pick_value());
      else add_req(OP_POP, value_t'($urandom()));
    end
  endtask

  task automatic wait_drained();
    while (taken_reqs != issued_reqs || expected_stack_rsp.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pops, extremes, encoded entries, equal minimum, refill after empty
    add_req(OP_POP, '1);
    add_req(OP_PUSH, '1);
    add_req(OP_PUSH, '0);
    add_req(OP_PUSH, '0);
    add_req(OP_PUSH, '1);
    add_req(OP_POP, '0);
    add_req(OP_POP, '1);
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    add_req(OP_PUSH, value_t'(5));
    add_req(OP_PUSH, value_t'(3));
    add_req(OP_PUSH, value_t'(3));
    add_req(OP_PUSH, value_t'(1));
    add_req(OP_PUSH, value_t'(30'h2AAA_AAAA));
    add_req(OP_PUSH, value_t'(0));
    add_req(OP_POP, value_t'(30'h1555_5555));
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    add_req(OP_POP, '0);
    wait_drained();

    // idling phases: none, sender, receiver, both
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 63 : (p == 3) ? 24 : 0;
      stall_pct = (p == 2) ? 63 : (p == 3) ? 24 : 0;
      add_random(140);
      wait_drained();
    end

    // receiver holds off while the sender keeps offering requests
    send_idle_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    add_random(60);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (expected_stack_rsp.size() != 0) begin
      $error("%0d expected results never arrived", expected_stack_rsp.size());
      errors++;
    end
    if (errors == 0) begin
      $display("min_tracking_stack_core: match");
    end else begin
      $display("min_tracking_stack_core: mismatch");
    end
    $finish;
  end

endmodule
